// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl of dedup_multiclass_fifo
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DMCF_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define DMCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DMCF_ASSERT_ALWAYS(lbl, expr)
`define DMCF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/dmcf_pkg.sv =====
// types and constants of the multi-class job queue
// no dependencies
package dmcf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_BITS    = 16;
  localparam int CLASS_COUNT = 4;

  localparam int KEY_W   = 16;
  localparam int CLASS_W = 2;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W   = 5;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_NONE = 2'd3
  } status_t;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef struct packed {
    logic               op;
    logic [KEY_W-1:0]   job_key;
    logic [CLASS_W-1:0] job_class;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] key_out;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic                enq_go;
    logic                deq;
    logic [KEY_BITS-1:0] key;
    logic [CLASS_W-1:0]  cls;
  } dmcf_bus_t;

endpackage

// ===== rtl/dmcf_cell.sv =====
// one queue slot: key and class, compare logic and shift from the younger neighbour
// depends on dmcf_pkg
module dmcf_cell (
  input  logic                          clk,
  input  dmcf_pkg::dmcf_bus_t           bus,
  input  logic                          live,
  input  logic                          tail,
  input  logic                          found_in,
  input  logic [dmcf_pkg::KEY_BITS-1:0] nb_key,
  input  logic [dmcf_pkg::CLASS_W-1:0]  nb_cls,
  output logic [dmcf_pkg::KEY_BITS-1:0] key_r,
  output logic [dmcf_pkg::CLASS_W-1:0]  cls_r,
  output logic                          found_out,
  output logic                          key_hit,
  output logic                          first_hit
);

  logic class_hit;

  assign class_hit = live && bus.deq && (cls_r == bus.cls);
  assign key_hit   = live && (key_r == bus.key);
  assign first_hit = class_hit && !found_in;
  assign found_out = found_in || class_hit;

  always_ff @(posedge clk) begin
    if (bus.enq_go && tail) begin
      key_r <= bus.key;
      cls_r <= bus.cls;
    end else if (found_out) begin
      key_r <= nb_key;
      cls_r <= nb_cls;
    end
  end

endmodule

// ===== rtl/dedup_multiclass_fifo.sv =====
// top level of the multi-class job queue with duplicate rejection
// depends on dmcf_pkg, dmcf_cell and assert_macros.svh
//
// At most one operation is taken per cycle: the whole row of slot cells compares the
// key or class of the transfer in the same cycle and updates at its end, so
// the result appears in the output register in the cycle after the input
// transfer. in_ready stays high while the output register is empty or being
// taken, so back-to-back operations run at one per cycle. Slot contents have
// no reset; only the entry count and the output valid flag are cleared.
`include "assert_macros.svh"

module dedup_multiclass_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dmcf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dmcf_pkg::out_item_t out_data
);

  localparam int DEPTH = dmcf_pkg::QUEUE_DEPTH;

  logic [dmcf_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic                          out_valid_r;
  dmcf_pkg::out_item_t           out_data_r, out_data_nxt;
  dmcf_pkg::dmcf_bus_t           bus;

  logic [dmcf_pkg::KEY_BITS-1:0] cell_key [DEPTH];
  logic [dmcf_pkg::CLASS_W-1:0]  cell_cls [DEPTH];
  logic [DEPTH:0]                found;
  logic [DEPTH-1:0]              key_hit;
  logic [DEPTH-1:0]              first_hit;

  logic                          in_xfer;
  logic                          is_enq, is_deq;
  logic                          class_ok, dup, full, deq_ok;
  logic [dmcf_pkg::KEY_BITS-1:0] got_key;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign is_enq   = in_data.op == dmcf_pkg::OP_ENQ;
  assign is_deq   = in_data.op == dmcf_pkg::OP_DEQ;

  assign class_ok = int'(in_data.job_class) < dmcf_pkg::CLASS_COUNT;
  assign dup      = |key_hit;
  assign full     = count_r == dmcf_pkg::COUNT_W'(DEPTH);
  assign deq_ok   = found[DEPTH];

  always_comb begin
    bus.enq_go = in_xfer && is_enq && class_ok && !dup && !full;
    bus.deq    = in_xfer && is_deq;
    bus.key    = in_data.job_key[dmcf_pkg::KEY_BITS-1:0];
    bus.cls    = in_data.job_class;
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [dmcf_pkg::KEY_BITS-1:0] nb_key;
    logic [dmcf_pkg::CLASS_W-1:0]  nb_cls;

    if (i == DEPTH - 1) begin : g_last
      assign nb_key = cell_key[i];
      assign nb_cls = cell_cls[i];
    end else begin : g_mid
      assign nb_key = cell_key[i+1];
      assign nb_cls = cell_cls[i+1];
    end

    dmcf_cell u_cell (
      .clk       (clk),
      .bus       (bus),
      .live      (dmcf_pkg::COUNT_W'(i) < count_r),
      .tail      (dmcf_pkg::COUNT_W'(i) == count_r),
      .found_in  (found[i]),
      .nb_key    (nb_key),
      .nb_cls    (nb_cls),
      .key_r     (cell_key[i]),
      .cls_r     (cell_cls[i]),
      .found_out (found[i+1]),
      .key_hit   (key_hit[i]),
      .first_hit (first_hit[i])
    );
  end

  always_comb begin
    got_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      got_key = got_key | (cell_key[i] & {dmcf_pkg::KEY_BITS{first_hit[i]}});
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (bus.enq_go) begin
      count_nxt = count_r + dmcf_pkg::COUNT_W'(1);
    end else if (bus.deq && deq_ok) begin
      count_nxt = count_r - dmcf_pkg::COUNT_W'(1);
    end
  end

  always_comb begin
    out_data_nxt.key_out   = '0;
    out_data_nxt.occupancy = dmcf_pkg::OCC_W'(count_nxt);
    priority if (is_deq) begin
      out_data_nxt.status = deq_ok ? dmcf_pkg::ST_OK : dmcf_pkg::ST_NONE;
      if (deq_ok) begin
        out_data_nxt.key_out = dmcf_pkg::KEY_W'(got_key);
      end
    end else if (!class_ok) begin
      out_data_nxt.status = dmcf_pkg::ST_NONE;
    end else if (dup) begin
      out_data_nxt.status = dmcf_pkg::ST_DUP;
    end else if (full) begin
      out_data_nxt.status = dmcf_pkg::ST_FULL;
    end else begin
      out_data_nxt.status = dmcf_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `DMCF_ASSERT_ALWAYS(a_count_bound, count_r <= dmcf_pkg::COUNT_W'(DEPTH))
  `DMCF_ASSERT_NEXT(a_result_follows, in_xfer, out_valid_r)
  `DMCF_ASSERT_NEXT(a_enq_grows, bus.enq_go, count_r == $past(count_r) + dmcf_pkg::COUNT_W'(1))

endmodule

// ===== bench/tb_dedup_multiclass_fifo.sv =====
// testbench for dedup_multiclass_fifo: directed and random enqueue/dequeue traffic
// checked against a shadow copy of the job queue kept in a small class
// depends on dmcf_pkg and the rtl of dedup_multiclass_fifo
module tb_dedup_multiclass_fifo;
  import dmcf_pkg::*;

  localparam int unsigned RANDOM_OPS  = 1900;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_WAIT  = 8;

  class job_queue_shadow;
    logic [KEY_BITS-1:0] keys[QUEUE_DEPTH];
    logic [CLASS_W-1:0]  classes[QUEUE_DEPTH];
    int unsigned         fill;
    out_item_t           awaited[$];
    int unsigned         errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function void take_op(in_item_t item);
      out_item_t           want;
      logic [KEY_BITS-1:0] k;
      status_t             st;
      int                  hit;
      k = item.job_key[KEY_BITS-1:0];
      want.key_out = '0;
      hit = -1;
      if (item.op == OP_ENQ) begin
        if (item.job_class >= CLASS_COUNT) begin
          st = ST_NONE;
        end else begin
          for (int i = 0; i < fill; i++)
            if (keys[i] == k && hit < 0) hit = i;
          if (hit >= 0) begin
            st = ST_DUP;
          end else if (fill >= QUEUE_DEPTH) begin
            st = ST_FULL;
          end else begin
            keys[fill] = k;
            classes[fill] = item.job_class;
            fill++;
            st = ST_OK;
          end
        end
      end else begin
        for (int i = 0; i < fill; i++)
          if (classes[i] == item.job_class && hit < 0) hit = i;
        if (hit < 0) begin
          st = ST_NONE;
        end else begin
          want.key_out = KEY_W'(keys[hit]);
          for (int j = hit; j + 1 < fill; j++) begin
            keys[j] = keys[j+1];
            classes[j] = classes[j+1];
          end
          fill--;
          st = ST_OK;
        end
      end
      want.status = st;
      want.occupancy = OCC_W'(fill);
      awaited.push_back(want);
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        $error("result %h with no operation outstanding", got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status expected %0d got %0d", want.status, got.status);
        errors++;
      end
      if (got.key_out !== want.key_out) begin
        $error("key_out expected %h got %h", want.key_out, got.key_out);
        errors++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy expected %0d got %0d", want.occupancy, got.occupancy);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  job_queue_shadow     shadow = new();
  logic [KEY_W-1:0]    key_pool[32];
  int unsigned         cycles = 0;

  dedup_multiclass_fifo u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_op(op_t op, logic [KEY_W-1:0] key, logic [CLASS_W-1:0] cls);
    in_item_t it;
    it.op = op;
    it.job_key = key;
    it.job_class = cls;
    return it;
  endfunction

  function automatic in_item_t random_op(bit fill_phase);
    in_item_t    it;
    int unsigned r;
    it.op = OP_ENQ;
    it.job_key = KEY_W'($urandom);
    it.job_class = CLASS_W'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 8) begin
      it.op = op_t'($urandom_range(0, 1));
      return it;
    end
    if ($urandom_range(0, 99) < (fill_phase ? 75 : 30)) begin
      r = $urandom_range(0, 99);
      if (r < 25 && shadow.fill > 0)
        it.job_key = KEY_W'(shadow.keys[$urandom_range(0, shadow.fill - 1)]);
      else if (r < 65)
        it.job_key = key_pool[$urandom_range(0, 31)];
    end else begin
      it.op = OP_DEQ;
      if ($urandom_range(0, 99) < 80 && shadow.fill > 0)
        it.job_class = shadow.classes[$urandom_range(0, shadow.fill - 1)];
    end
    return it;
  endfunction

  task automatic send_op(in_item_t item, int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    shadow.take_op(item);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (shadow.awaited.size() != 0);
  endtask

  // receiver: random stalls, calm stretches, and two long hold-offs
  initial begin
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned taken;
    stall_left = 0;
    calm_left = 0;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        shadow.check_reply(out_data);
        taken++;
        if (taken == 300 || taken == 1300) stall_left = 150;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(0, 99) < 3) begin
          calm_left = $urandom_range(50, 150);
        end else if ($urandom_range(0, 99) < 30) begin
          stall_left = idle_len();
        end
      end
    end
  end

  initial begin
    bit          fill_phase;
    bit          calm;
    int unsigned phase_left;
    int unsigned gap;
    logic [CLASS_W-1:0] fill_cls[3];
    fill_cls[0] = 2'd0;
    fill_cls[1] = 2'd1;
    fill_cls[2] = 2'd3;
    for (int i = 0; i < 32; i++) key_pool[i] = KEY_W'($urandom);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty dequeue, key extremes, duplicate, fill, full, dup while full, dequeues by class
    send_op(make_op(OP_DEQ, 16'h0000, 2'd0), 0);
    send_op(make_op(OP_ENQ, 16'h0000, 2'd0), 0);
    send_op(make_op(OP_ENQ, 16'hffff, 2'd3), 1);
    send_op(make_op(OP_ENQ, 16'hffff, 2'd1), 0);
    for (int i = 0; i < 14; i++)
      send_op(make_op(OP_ENQ, KEY_W'(16'h1000 + i * 16'h0111), fill_cls[i % 3]), i % 2);
    send_op(make_op(OP_ENQ, 16'h5a5a, 2'd2), 0);
    send_op(make_op(OP_ENQ, 16'h0000, 2'd1), 0);
    send_op(make_op(OP_DEQ, 16'hffff, 2'd2), 0);
    send_op(make_op(OP_DEQ, 16'h0000, 2'd0), 2);
    send_op(make_op(OP_DEQ, 16'h0000, 2'd1), 0);
    send_op(make_op(OP_DEQ, 16'h0000, 2'd3), 0);

    fill_phase = 1'b1;
    calm = 1'b0;
    phase_left = $urandom_range(20, 60);
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (phase_left == 0) begin
        fill_phase = !fill_phase;
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      if (n % 150 == 0 && $urandom_range(0, 99) < 30) calm = !calm;
      if (n == 900) wait_all_results();
      gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
      send_op(random_op(fill_phase), gap);
    end

    wait_all_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (shadow.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
